@@ sv/igcf_pkg.sv @@
// ----------------------------------------------------------------------------
// igcf_pkg: shared types and constants for the instant gated config queue
// Opcodes, status codes, default sizes and the stream field widths.
// ----------------------------------------------------------------------------
package igcf_pkg;

    // Default number of ring slots (one slot always stays free).
    localparam int SLOTS_DEF        = 8;
    // Default stored payload width.
    localparam int PAYLOAD_BITS_DEF = 64;

    // Fixed field widths of the stream items.
    localparam int OP_W      = 2;
    localparam int INSTANT_W = 16;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 3;

    // Slave tdata: release_instant, event_count, payload_in (96 bits, whole bytes).
    localparam int S_TDATA_W = 96;
    // Master tdata: payload_out, entry_count, zero fill up to 72 bits.
    localparam int M_TDATA_W = 72;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_LATEST  = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOT_DUE = 2'd3
    } t_status;

    // Result item as held in the output register.
    typedef struct packed {
        t_status                status;
        logic [PAYLOAD_W-1:0]   payload;
        logic [COUNT_W-1:0]     count;
    } t_result;

endpackage

@@ sv/igcf_cell.sv @@
// ----------------------------------------------------------------------------
// igcf_cell: one storage cell of the queue chain
// Holds one release instant and one payload word, and loads the entry on its
// inputs (its neighbor's, or the new item for the first cell) whenever the chain shifts on an enqueue.
// ----------------------------------------------------------------------------
module igcf_cell #(
    parameter int PAYLOAD_BITS = igcf_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_shift,
    input  logic [igcf_pkg::INSTANT_W-1:0]    i_instant,
    input  logic [PAYLOAD_BITS-1:0]           i_payload,
    output logic [igcf_pkg::INSTANT_W-1:0]    o_instant,
    output logic [PAYLOAD_BITS-1:0]           o_payload
);
    import igcf_pkg::*;

    logic [INSTANT_W-1:0]    r_instant;
    logic [PAYLOAD_BITS-1:0] r_payload;

    // Entry storage; contents are meaningless until the first shift reaches it.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_instant <= i_instant;
            r_payload <= i_payload;
        end
    end

    assign o_instant = r_instant;
    assign o_payload = r_payload;

endmodule

@@ sv/instant_gated_config_fifo.sv @@
// ----------------------------------------------------------------------------
// instant_gated_config_fifo: release-instant gated queue of payload words
// Each accepted item's result is registered and shown on the master side in the next cycle.
// Throughput: 1 item per cycle; a new item is taken whenever the output
// register is empty or its result is being taken in the same cycle.
// The rate is set by the single head select and 16-bit due compare.
// Reset (synchronous, active low) empties the queue and the output register.
// ----------------------------------------------------------------------------
module instant_gated_config_fifo #(
    parameter int SLOTS        = igcf_pkg::SLOTS_DEF,
    parameter int PAYLOAD_BITS = igcf_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input items
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] release_instant, [31:16] event_count, [95:32] payload_in
    input  logic [igcf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [1:0] opcode
    input  logic [igcf_pkg::OP_W-1:0]         s_axis_tuser,
    // Result items
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [63:0] payload_out, [66:64] entry_count, [71:67] zero
    output logic [igcf_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [igcf_pkg::STATUS_W-1:0]     m_axis_tuser
);
    import igcf_pkg::*;

    localparam int CELLS = SLOTS - 1;
    localparam int CW    = $clog2(SLOTS);
    localparam logic [CW-1:0] FULL_COUNT = CW'(SLOTS - 1);

    // Unpacked input fields.
    t_op                     w_op;
    logic [INSTANT_W-1:0]    w_instant;
    logic [INSTANT_W-1:0]    w_event;
    logic [PAYLOAD_BITS-1:0] w_payload;
    logic                    w_accept;

    assign w_op      = t_op'(s_axis_tuser);
    assign w_instant = s_axis_tdata[15:0];
    assign w_event   = s_axis_tdata[31:16];
    assign w_payload = s_axis_tdata[32 +: PAYLOAD_BITS];
    assign w_accept  = s_axis_tvalid && s_axis_tready;

    // Queue fill level and output register.
    logic [CW-1:0] r_count, n_count;
    logic          r_valid;
    t_result       r_result, n_result;

    // Chain of cells: cell 0 always holds the newest entry, the head sits
    // at cell count-1.
    logic                    w_shift;
    logic [INSTANT_W-1:0]    w_cell_inst [CELLS];
    logic [PAYLOAD_BITS-1:0] w_cell_pay  [CELLS];

    generate
        for (genvar k = 0; k < CELLS; k++) begin : g_cell
            if (k == 0) begin : g_first
                igcf_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                    .i_clk     (i_clk),
                    .i_shift   (w_shift),
                    .i_instant (w_instant),
                    .i_payload (w_payload),
                    .o_instant (w_cell_inst[k]),
                    .o_payload (w_cell_pay[k])
                );
            end else begin : g_next
                igcf_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
                    .i_clk     (i_clk),
                    .i_shift   (w_shift),
                    .i_instant (w_cell_inst[k-1]),
                    .i_payload (w_cell_pay[k-1]),
                    .o_instant (w_cell_inst[k]),
                    .o_payload (w_cell_pay[k])
                );
            end
        end
    endgenerate

    // Head entry and its serial-number due test.
    logic [CW-1:0]           w_head_idx;
    logic [INSTANT_W-1:0]    w_diff;
    logic                    w_due;
    logic                    w_empty;
    logic                    w_full;

    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == FULL_COUNT);
    assign w_head_idx = r_count - CW'(1);
    assign w_diff     = w_cell_inst[w_head_idx] - w_event;
    assign w_due      = (w_diff == '0) || w_diff[INSTANT_W-1];
    assign w_shift    = w_accept && (w_op == OP_ENQUEUE) && !w_full;

    // Per-opcode next count and result.
    logic [8:0] w_count_wide;

    always_comb begin
        n_count          = r_count;
        n_result.status  = ST_DONE;
        n_result.payload = '0;
        case (w_op)
            OP_ENQUEUE: begin
                if (w_full) begin
                    n_result.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            OP_DEQUEUE: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else if (w_due) begin
                    n_result.payload = PAYLOAD_W'(w_cell_pay[w_head_idx]);
                    n_count          = r_count - CW'(1);
                end else begin
                    n_result.status = ST_NOT_DUE;
                end
            end
            OP_LATEST: begin
                if (w_empty) begin
                    n_result.status = ST_EMPTY;
                end else begin
                    n_result.payload = PAYLOAD_W'(w_cell_pay[0]);
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        w_count_wide   = 9'(n_count);
        n_result.count = w_count_wide[COUNT_W-1:0];
    end

    // Fill level and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_result.count, r_result.payload};
    assign m_axis_tuser  = r_result.status;

    // Checks on the queue bookkeeping.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("queue fill level beyond capacity");

    a_enqueue_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_ENQUEUE && !w_full) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("stored enqueue did not grow the queue");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear item left entries behind");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.status != ST_DONE) |-> (r_result.payload == '0))
        else $error("payload not zero on a failing status");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the instant gated config queue
// A directed table covers the empty, full and serial-compare corner cases.
// Random traffic then follows a moving event clock, so most dequeues land
// near the due boundary. Every result is checked against a local predictor or
// a hand-written expectation, and both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
    import igcf_pkg::*;

    localparam int CLK_PERIOD = 8;
    localparam int SLOTS      = SLOTS_DEF;
    localparam int PTR_W      = $clog2(SLOTS) + 1;
    localparam int DIRECTED_N = 25;
    localparam int RANDOM_N   = 1800;
    localparam int IDLE_PCT   = 38;
    localparam int HOLD_LEN   = 250;
    localparam int STALL_MAX  = 2000;

    // One stimulus item, with an optional hand-written expected result.
    typedef struct {
        t_op             op;
        logic [15:0]     instant;
        logic [15:0]     count;
        logic [63:0]     payload;
        bit              typed;
        t_result         want;
    } t_cmd_row;

    localparam t_result UNTYPED = '{ST_DONE, 64'h0, 3'd0};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // Predictor copy of the ring.
    logic [63:0]           pay_mem [SLOTS];
    logic [15:0]           inst_mem [SLOTS];
    logic [PTR_W-1:0]      wr_ptr = '0;
    logic [PTR_W-1:0]      rd_ptr = '0;
    logic [15:0]           event_now = '0;

    t_result               pending_results [$];
    int                    errors = 0;
    int                    results_seen = 0;
    int                    op_seen [4] = '{0, 0, 0, 0};
    int                    status_seen [4] = '{0, 0, 0, 0};
    bit                    calm = 1'b0;

    // Hand-checked corner cases: empty reads, serial compare edges, full drop.
    t_cmd_row directed_rows [DIRECTED_N] = '{
        '{OP_DEQUEUE, 16'h0000, 16'h1234, 64'h0, 1'b1, '{ST_EMPTY, 64'h0, 3'd0}},
        '{OP_LATEST,  16'h0000, 16'h0000, 64'h0, 1'b1, '{ST_EMPTY, 64'h0, 3'd0}},
        '{OP_ENQUEUE, 16'h0000, 16'h0000, 64'h0, 1'b1, '{ST_DONE, 64'h0, 3'd1}},
        '{OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
          '{ST_DONE, 64'h0, 3'd2}},
        '{OP_LATEST,  16'h0000, 16'h0000, 64'h0, 1'b1,
          '{ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 3'd2}},
        '{OP_DEQUEUE, 16'h0000, 16'hFFFF, 64'h0, 1'b1, '{ST_NOT_DUE, 64'h0, 3'd2}},
        '{OP_DEQUEUE, 16'h0000, 16'h0000, 64'h0, 1'b1, '{ST_DONE, 64'h0, 3'd1}},
        '{OP_DEQUEUE, 16'h0000, 16'h7FFF, 64'h0, 1'b1,
          '{ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0}},
        '{OP_ENQUEUE, 16'h8000, 16'h0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, UNTYPED},
        '{OP_ENQUEUE, 16'h7FFF, 16'h0000, 64'h5555_5555_5555_5555, 1'b0, UNTYPED},
        '{OP_ENQUEUE, 16'h0001, 16'h0000, 64'h8000_0000_0000_0001, 1'b0, UNTYPED},
        '{OP_ENQUEUE, 16'h1234, 16'h0000, 64'h0123_4567_89AB_CDEF, 1'b0, UNTYPED},
        '{OP_ENQUEUE, 16'hFFFE, 16'h0000, 64'hFEDC_BA98_7654_3210, 1'b0, UNTYPED},
        '{OP_ENQUEUE, 16'h4000, 16'h0000, 64'h0000_0000_0000_0001, 1'b0, UNTYPED},
        '{OP_ENQUEUE, 16'hC000, 16'h0000, 64'h8000_0000_0000_0000, 1'b0, UNTYPED},
        '{OP_ENQUEUE, 16'h0000, 16'h0000, 64'h0000_0000_0000_DEAD, 1'b1,
          '{ST_FULL, 64'h0, 3'd7}},
        '{OP_LATEST,  16'h0000, 16'h0000, 64'h0, 1'b0, UNTYPED},
        '{OP_DEQUEUE, 16'h0000, 16'h0001, 64'h0, 1'b1, '{ST_NOT_DUE, 64'h0, 3'd7}},
        '{OP_DEQUEUE, 16'h0000, 16'h0000, 64'h0, 1'b0, UNTYPED},
        '{OP_DEQUEUE, 16'h0000, 16'h7FFF, 64'h0, 1'b0, UNTYPED},
        '{OP_CLEAR,   16'h0000, 16'h0000, 64'h0, 1'b1, '{ST_DONE, 64'h0, 3'd0}},
        '{OP_DEQUEUE, 16'h0000, 16'h0000, 64'h0, 1'b1, '{ST_EMPTY, 64'h0, 3'd0}},
        '{OP_CLEAR,   16'h0000, 16'h0000, 64'h0, 1'b1, '{ST_DONE, 64'h0, 3'd0}},
        '{OP_ENQUEUE, 16'h5555, 16'h0000, 64'h0000_0000_0000_0042, 1'b1,
          '{ST_DONE, 64'h0, 3'd1}},
        '{OP_LATEST,  16'h0000, 16'h0000, 64'h0, 1'b0, UNTYPED}
    };

    instant_gated_config_fifo uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Apply one item to the predicted ring and return its status result.
    function automatic t_result queue_step(t_cmd_row r);
        t_result          res;
        logic [PTR_W-1:0] fill;
        logic [PTR_W-1:0] newest;
        logic [15:0]      gap;
        fill = wr_ptr - rd_ptr;
        res.status = ST_DONE;
        res.payload = '0;
        case (r.op)
            OP_ENQUEUE: begin
                if (fill >= PTR_W'(SLOTS - 1)) begin
                    res.status = ST_FULL;
                end else begin
                    pay_mem[wr_ptr[PTR_W-2:0]] = r.payload;
                    inst_mem[wr_ptr[PTR_W-2:0]] = r.instant;
                    wr_ptr = wr_ptr + 1'b1;
                end
            end
            OP_DEQUEUE: begin
                if (fill == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // Serial compare: due when the gap is zero or wraps negative.
                    gap = inst_mem[rd_ptr[PTR_W-2:0]] - r.count;
                    if (gap == 16'h0 || gap[15]) begin
                        res.payload = pay_mem[rd_ptr[PTR_W-2:0]];
                        rd_ptr = rd_ptr + 1'b1;
                    end else begin
                        res.status = ST_NOT_DUE;
                    end
                end
            end
            OP_LATEST: begin
                if (fill == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    newest = wr_ptr - 1'b1;
                    res.payload = pay_mem[newest[PTR_W-2:0]];
                end
            end
            default: begin
                wr_ptr = '0;
                rd_ptr = '0;
            end
        endcase
        fill = wr_ptr - rd_ptr;
        res.count = fill[COUNT_W-1:0];
        return res;
    endfunction

    // Random item that tracks a moving event clock, so that most dequeues
    // fall near the due boundary of the current head.
    function automatic t_cmd_row pick_random_row();
        t_cmd_row         r;
        int               roll;
        logic [PTR_W-1:0] fill;
        logic [15:0]      head;
        logic [15:0]      gap;
        r.typed = 1'b0;
        r.want = UNTYPED;
        r.payload = {$urandom, $urandom};
        r.instant = 16'($urandom);
        r.count = 16'($urandom);
        event_now = event_now + 16'($urandom_range(0, 3));
        fill = wr_ptr - rd_ptr;
        head = (fill != '0) ? inst_mem[rd_ptr[PTR_W-2:0]] : 16'h0;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            r.op = OP_ENQUEUE;
            if ($urandom_range(0, 9) != 0) begin
                r.instant = event_now + 16'($urandom_range(0, 40));
            end
        end else if (roll < 85) begin
            r.op = OP_DEQUEUE;
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                r.count = event_now;
            end else if (roll < 85 && fill != '0) begin
                case ($urandom_range(0, 5))
                    0: gap = 16'h0000;
                    1: gap = 16'h0001;
                    2: gap = 16'h7FFF;
                    3: gap = 16'h8000;
                    4: gap = 16'h8001;
                    default: gap = 16'hFFFF;
                endcase
                r.count = head - gap;
            end
        end else if (roll < 97) begin
            r.op = OP_LATEST;
        end else begin
            r.op = OP_CLEAR;
        end
        return r;
    endfunction

    // Offer one item, wait for the handshake, then record its expected result.
    task automatic offer_item(input t_cmd_row r);
        t_result want;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r.payload, r.count, r.instant};
        s_axis_tuser <= r.op;
        do @(posedge i_clk); while (!s_axis_tready);
        want = queue_step(r);
        if (r.typed) begin
            want = r.want;
        end
        pending_results.push_back(want);
        op_seen[r.op]++;
        status_seen[want.status]++;
    endtask

    // Compare one taken result against the oldest expectation.
    task automatic check_result(input logic [M_TDATA_W-1:0] data,
                                input logic [STATUS_W-1:0] user);
        t_result want;
        results_seen++;
        if (pending_results.size() == 0) begin
            $error("result with no item pending: status %0d, data %h", user, data);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (user !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, user);
            errors++;
        end
        if (data[63:0] !== want.payload) begin
            $error("payload_out: expected %h, actual %h", want.payload, data[63:0]);
            errors++;
        end
        if (data[66:64] !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, data[66:64]);
            errors++;
        end
        if (data[71:67] !== 5'd0) begin
            $error("tdata fill: expected 0, actual %h", data[71:67]);
            errors++;
        end
    endtask

    // Result side: random stalls plus one long hold-off that backs up the queue.
    initial begin : result_sink
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata, m_axis_tuser);
            end
            if (!hold_done && results_seen >= 400) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no handshake.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_MAX) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("timeout after %0d cycles without a handshake", STALL_MAX);
        $display("instant_gated_config_fifo: mismatch");
        $finish;
    end

    // Main sequence: reset, directed table, random traffic, drain.
    initial begin : stimulus
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < DIRECTED_N; i++) begin
            offer_item(directed_rows[i]);
        end
        for (int n = 0; n < RANDOM_N; n++) begin
            // A stretch in the middle runs with no stalls on either side.
            calm <= (n >= 700 && n < 1000);
            offer_item(pick_random_row());
        end
        s_axis_tvalid <= 1'b0;
        calm <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end
        $display("Covered %0d items: %0d enqueue, %0d dequeue, %0d latest, %0d clear.",
                 DIRECTED_N + RANDOM_N, op_seen[OP_ENQUEUE], op_seen[OP_DEQUEUE],
                 op_seen[OP_LATEST], op_seen[OP_CLEAR]);
        $display("Statuses: %0d done, %0d full drops, %0d empty, %0d not due.",
                 status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_NOT_DUE]);
        if (errors == 0) begin
            $display("instant_gated_config_fifo: match");
        end else begin
            $display("instant_gated_config_fifo: mismatch");
        end
        $finish;
    end

endmodule
